// ===== hw/rtl/bpsf_pkg.sv =====
`default_nettype none
package bpsf_pkg;
  localparam int FracBitsDefault = 16;
  localparam int PosW  = 32;
  localparam int DiffW = 33;
  localparam int MagW  = 32;
  localparam int SqW   = 64;
  localparam int SumW  = 66;
  localparam int LenW  = 33;
  localparam int ParW  = 31;
  localparam int StrW  = 34;
  localparam int ProdW = 65;
  localparam int NumW  = 97;
endpackage
`default_nettype wire

// ===== hw/rtl/bungee_pair_spring_force_core.sv =====
// Channel | Direction | Handshake    | Payload
// in      | input     | valid, stall | pos_a_*, pos_b_*, rest_length, spring_stiffness
// out     | output    | out_valid, out_stall | force_x/y/z, stretched
//
// Fixed pipeline of 139 stages: 33 square-root steps and 97 divide steps,
// one bit per stage, dominate the latency. One transfer is accepted per cycle while out_stall is low.
// A stall on the output freezes every stage, and the input stall is the output
// stall itself, so nothing is lost or repeated.
// Reset clears the valid bits of all stages.
`default_nettype none
module bungee_pair_spring_force_core #(
  parameter int FRAC_BITS = bpsf_pkg::FracBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             stall,
  input  wire logic signed [31:0] pos_a_x,
  input  wire logic signed [31:0] pos_a_y,
  input  wire logic signed [31:0] pos_a_z,
  input  wire logic signed [31:0] pos_b_x,
  input  wire logic signed [31:0] pos_b_y,
  input  wire logic signed [31:0] pos_b_z,
  input  wire logic [30:0] rest_length,
  input  wire logic [30:0] spring_stiffness,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic signed [31:0] force_z,
  output logic             stretched
);
  localparam int SqSteps  = bpsf_pkg::LenW;
  localparam int DivSteps = bpsf_pkg::NumW;
  localparam int DenW     = bpsf_pkg::LenW + FRAC_BITS;
  localparam int RemW     = DenW + 1;

  logic adv;
  assign adv   = !out_stall;
  assign stall = out_stall;

  typedef struct packed {
    logic [2:0]                  neg;
    logic [2:0][bpsf_pkg::MagW:0] mag;
    logic [30:0]                 rest;
    logic [30:0]                 k;
  } side_t;

  // Stage 1: differences and magnitudes.
  logic  v1;
  side_t s1;
  logic signed [bpsf_pkg::DiffW-1:0] dx, dy, dz;
  always_comb begin
    dx = {pos_a_x[31], pos_a_x} - {pos_b_x[31], pos_b_x};
    dy = {pos_a_y[31], pos_a_y} - {pos_b_y[31], pos_b_y};
    dz = {pos_a_z[31], pos_a_z} - {pos_b_z[31], pos_b_z};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= valid;
    end
    if (adv) begin
      s1.neg    <= {dz[32], dy[32], dx[32]};
      s1.mag[0] <= dx[32] ? 33'(-dx) : 33'(dx);
      s1.mag[1] <= dy[32] ? 33'(-dy) : 33'(dy);
      s1.mag[2] <= dz[32] ? 33'(-dz) : 33'(dz);
      s1.rest   <= rest_length;
      s1.k      <= spring_stiffness;
    end
  end

  // Stage 2: squares.
  logic v2;
  side_t s2;
  logic [2:0][bpsf_pkg::SqW+1:0] sq2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      s2 <= s1;
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= 66'(s1.mag[i] * s1.mag[i]);
      end
    end
  end

  // Stage 3: sum of squares.
  logic v3;
  side_t s3;
  logic [bpsf_pkg::SumW:0] sum3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      s3   <= s2;
      sum3 <= 67'(sq2[0]) + 67'(sq2[1]) + 67'(sq2[2]);
    end
  end

  // Square root, one result bit per stage (restoring, remainder form).
  logic  [SqSteps:0] vq;
  side_t             sq_side [SqSteps+1];
  logic [bpsf_pkg::SumW:0] sq_val [SqSteps+1];
  logic [bpsf_pkg::LenW-1:0] sq_root [SqSteps+1];
  logic [bpsf_pkg::SumW+1:0] sq_rem [SqSteps+1];
  assign vq[0]      = v3;
  assign sq_side[0] = s3;
  assign sq_val[0]  = sum3;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  for (genvar g = 0; g < SqSteps; g++) begin : g_sqrt
    localparam int B = SqSteps - 1 - g;
    logic [bpsf_pkg::SumW+1:0] rem_sh, trial;
    always_comb begin
      rem_sh = {sq_rem[g][bpsf_pkg::SumW-1:0], sq_val[g][2*B+1], sq_val[g][2*B]};
      trial  = {33'd0, sq_root[g], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vq[g+1] <= 1'b0;
      end else if (adv) begin
        vq[g+1] <= vq[g];
      end
      if (adv) begin
        sq_side[g+1] <= sq_side[g];
        sq_val[g+1]  <= sq_val[g];
        if (rem_sh >= trial) begin
          sq_rem[g+1]  <= rem_sh - trial;
          sq_root[g+1] <= {sq_root[g][bpsf_pkg::LenW-2:0], 1'b1};
        end else begin
          sq_rem[g+1]  <= rem_sh;
          sq_root[g+1] <= {sq_root[g][bpsf_pkg::LenW-2:0], 1'b0};
        end
      end
    end
  end

  side_t sL;
  logic [bpsf_pkg::LenW-1:0] lenL;
  assign sL   = sq_side[SqSteps];
  assign lenL = sq_root[SqSteps];

  // Stage A: branch decision and stretch.
  logic va, stra;
  side_t sa;
  logic [bpsf_pkg::LenW-1:0] lena;
  logic [bpsf_pkg::StrW-1:0] dla;
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= vq[SqSteps];
    end
    if (adv) begin
      sa   <= sL;
      lena <= lenL;
      stra <= (lenL != '0) && (lenL > 33'(sL.rest));
      dla  <= 34'(lenL) - 34'(sL.rest);
    end
  end

  // Stage B: m = k * (L - rest), 31 x 34 bits cut in two halves.
  logic vb, strb;
  side_t sb;
  logic [bpsf_pkg::LenW-1:0] lenb;
  logic [47:0] mlo_b, mhi_b;
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb <= va;
    end
    if (adv) begin
      sb    <= sa;
      lenb  <= lena;
      strb  <= stra;
      mlo_b <= 48'(sa.k * dla[16:0]);
      mhi_b <= 48'(sa.k * dla[33:17]);
    end
  end

  logic vc, strc;
  side_t sc;
  logic [bpsf_pkg::LenW-1:0] lenc;
  logic [bpsf_pkg::ProdW-1:0] mc;
  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (adv) begin
      vc <= vb;
    end
    if (adv) begin
      sc   <= sb;
      lenc <= lenb;
      strc <= strb;
      mc   <= 65'(mlo_b) + (65'(mhi_b) << 17);
    end
  end

  // Stage D: partial products of m * |d| (m split in a 33-bit low and a 32-bit high part).
  logic vd, strd;
  side_t sd;
  logic [bpsf_pkg::LenW-1:0] lend;
  logic [2:0][65:0] plo_d, phi_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (adv) begin
      vd <= vc;
    end
    if (adv) begin
      sd   <= sc;
      lend <= lenc;
      strd <= strc;
      for (int i = 0; i < 3; i++) begin
        plo_d[i] <= 66'(mc[32:0] * sc.mag[i]);
        phi_d[i] <= 66'(mc[64:33] * sc.mag[i]);
      end
    end
  end

  // Stage E: numerators.
  logic ve, stre;
  side_t se;
  logic [bpsf_pkg::LenW-1:0] lene;
  logic [2:0][bpsf_pkg::NumW:0] num_e;
  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (adv) begin
      ve <= vd;
    end
    if (adv) begin
      se   <= sd;
      lene <= lend;
      stre <= strd;
      for (int i = 0; i < 3; i++) begin
        num_e[i] <= 98'(plo_d[i]) + (98'(phi_d[i]) << 33);
      end
    end
  end

  // Restoring division, one quotient bit per stage, three lanes.
  typedef struct packed {
    logic       str;
    logic [2:0] neg;
  } dctl_t;
  logic  [DivSteps:0] vdv;
  dctl_t dv_ctl [DivSteps+1];
  logic [DenW-1:0] dv_den [DivSteps+1];
  logic [2:0][bpsf_pkg::NumW-1:0] dv_num [DivSteps+1];
  logic [2:0][RemW-1:0] dv_rem [DivSteps+1];
  logic [2:0][bpsf_pkg::NumW-1:0] dv_q [DivSteps+1];
  assign vdv[0]        = ve;
  assign dv_ctl[0].str = stre;
  assign dv_ctl[0].neg = se.neg;
  assign dv_den[0]     = DenW'(lene) << FRAC_BITS;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_num[0][i] = num_e[i][bpsf_pkg::NumW-1:0];
      dv_rem[0][i] = '0;
      dv_q[0][i]   = '0;
    end
  end
  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    localparam int B = DivSteps - 1 - g;
    logic [2:0][RemW:0] rsh;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rsh[i] = {dv_rem[g][i], dv_num[g][i][B]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vdv[g+1] <= 1'b0;
      end else if (adv) begin
        vdv[g+1] <= vdv[g];
      end
      if (adv) begin
        dv_ctl[g+1] <= dv_ctl[g];
        dv_den[g+1] <= dv_den[g];
        dv_num[g+1] <= dv_num[g];
        for (int i = 0; i < 3; i++) begin
          if (rsh[i] >= (RemW+1)'(dv_den[g])) begin
            dv_rem[g+1][i] <= RemW'(rsh[i] - (RemW+1)'(dv_den[g]));
            dv_q[g+1][i]   <= dv_q[g][i] | (bpsf_pkg::NumW'(1) << B);
          end else begin
            dv_rem[g+1][i] <= RemW'(rsh[i]);
            dv_q[g+1][i]   <= dv_q[g][i];
          end
        end
      end
    end
  end

  // Output stage: zero when not stretched, else sign and saturation.
  logic [2:0][31:0] fo;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!dv_ctl[DivSteps].str) begin
        fo[i] = '0;
      end else if (dv_ctl[DivSteps].neg[i]) begin
        fo[i] = (dv_q[DivSteps][i] > 97'h7FFFFFFF) ? 32'h7FFFFFFF
                                                  : dv_q[DivSteps][i][31:0];
      end else begin
        fo[i] = (dv_q[DivSteps][i] > 97'h80000000) ? 32'h80000000
                                                  : 32'(-dv_q[DivSteps][i][31:0]);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vdv[DivSteps];
    end
    if (adv) begin
      force_x   <= fo[0];
      force_y   <= fo[1];
      force_z   <= fo[2];
      stretched <= dv_ctl[DivSteps].str;
    end
  end

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !stretched |-> force_x == 0 && force_y == 0 && force_z == 0)
    else $error("force without stretch");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(force_x))
    else $error("output changed under stall");
  a_stall: assert property (@(posedge clk) stall == out_stall)
    else $error("stall mismatch");
endmodule
`default_nettype wire
